@@ rtl/rmj_pkg.sv @@
// shared types and constants of the radar measurement jacobian
// no dependencies; used by every file of the block by scoped names
package rmj_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ROOT_W    = 32;
   localparam int Q_W       = 32;
   localparam int WIDE_W    = 96;
   localparam int NUM_W     = WIDE_W + FRAC_BITS;
   localparam int SQRT_LAT  = ROOT_W + 1;
   localparam int DIV_LAT   = Q_W + 2;
   localparam int N_OUT     = 6;

   localparam int MINR_W     = 31;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [MINR_W-1:0] MINR_RESET = 31'd1;
   localparam logic [0:0] CSR_MIN_RANGE = 1'b0;

   localparam logic signed [DATA_W-1:0] UNIT = 32'sd1 <<< FRAC_BITS;

   typedef logic [NUM_W-1:0]  num_type;
   typedef logic [WIDE_W-1:0] den_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
   } req_data_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drange_dpx;
      logic signed [DATA_W-1:0] drange_dpy;
      logic signed [DATA_W-1:0] dbearing_dpx;
      logic signed [DATA_W-1:0] dbearing_dpy;
      logic signed [DATA_W-1:0] drate_dpx;
      logic signed [DATA_W-1:0] drate_dpy;
      logic                     too_close;
   } rsp_data_type;

   // geometry carried alongside the square root
   typedef struct packed {
      logic [DATA_W-1:0] px;
      logic [DATA_W-1:0] py;
      logic [PROD_W-1:0] s;
      logic [PROD_W-1:0] cm;
      logic              npx;
      logic              npy;
      logic              nc;
   } geom_type;

endpackage

@@ rtl/rmj_sqrt.sv @@
// pipelined integer square root, one root bit per stage, with side payload
// depends on rmj_pkg
module rmj_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  rmj_pkg::geom_type  in_geom,
   output logic               out_valid,
   output logic [rmj_pkg::ROOT_W-1:0] out_root,
   output rmj_pkg::geom_type  out_geom
);

   localparam int N = rmj_pkg::ROOT_W;

   logic [rmj_pkg::SQRT_LAT-1:0] v_ff;
   logic [N:0]                   rem_ff  [N+1];
   logic [N:0]                   rem_in  [N+1];
   logic [N-1:0]                 root_ff [N+1];
   logic [N-1:0]                 root_in [N+1];
   logic [rmj_pkg::PROD_W-1:0]   sh_ff   [N+1];
   logic [rmj_pkg::PROD_W-1:0]   sh_in   [N+1];
   rmj_pkg::geom_type            geom_ff [N+1];

   always_comb begin
      logic [N+2:0] rem_sh;
      logic [N+2:0] trial;
      rem_in[0]  = '0;
      root_in[0] = '0;
      sh_in[0]   = in_geom.s;
      for (int k = 0; k < N; k++) begin
         rem_sh = {rem_ff[k], sh_ff[k][rmj_pkg::PROD_W-1 -: 2]};
         trial  = {1'b0, root_ff[k], 2'b01};
         if (rem_sh >= trial) begin
            rem_in[k+1]  = (N+1)'(rem_sh - trial);
            root_in[k+1] = {root_ff[k][N-2:0], 1'b1};
         end else begin
            rem_in[k+1]  = rem_sh[N:0];
            root_in[k+1] = {root_ff[k][N-2:0], 1'b0};
         end
         sh_in[k+1] = {sh_ff[k][rmj_pkg::PROD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[rmj_pkg::SQRT_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geom_ff[0] <= in_geom;
         for (int k = 0; k <= N; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            sh_ff[k]   <= sh_in[k];
         end
         for (int k = 1; k <= N; k++) begin
            geom_ff[k] <= geom_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[rmj_pkg::SQRT_LAT-1];
   assign out_root  = root_ff[N];
   assign out_geom  = geom_ff[N];

endmodule

@@ rtl/rmj_div.sv @@
// pipelined restoring divider, one quotient bit per stage, signed saturated result
// depends on rmj_pkg
module rmj_div (
   input  logic                 clock,
   input  logic                 adv,
   input  rmj_pkg::num_type     num,
   input  rmj_pkg::den_type     den,
   input  logic                 neg,
   input  logic                 zero,
   output logic signed [rmj_pkg::DATA_W-1:0] quo
);

   localparam int Q  = rmj_pkg::Q_W;
   localparam int W  = rmj_pkg::WIDE_W;
   localparam int HW = rmj_pkg::NUM_W - Q;

   logic [W-1:0] rem_ff [Q+1];
   logic [W-1:0] rem_in [Q+1];
   logic [Q-1:0] nlo_ff [Q+1];
   logic [Q-1:0] nlo_in [Q+1];
   logic [Q-1:0] q_ff   [Q+1];
   logic [Q-1:0] q_in   [Q+1];
   logic [W-1:0] den_ff [Q+1];
   logic [Q:0]   ovf_ff;
   logic [Q:0]   neg_ff;
   logic [Q:0]   zero_ff;
   logic         ovf_in;
   logic [rmj_pkg::DATA_W-1:0] mag;
   logic [rmj_pkg::DATA_W-1:0] lim;
   logic signed [rmj_pkg::DATA_W-1:0] quo_in;
   logic signed [rmj_pkg::DATA_W-1:0] quo_ff;

   // quotient of 2^Q or more saturates at once
   always_comb begin
      logic [W:0] trial;
      ovf_in    = {{(W-HW){1'b0}}, num[rmj_pkg::NUM_W-1:Q]} >= den;
      rem_in[0] = ovf_in ? '0 : {{(W-HW){1'b0}}, num[rmj_pkg::NUM_W-1:Q]};
      nlo_in[0] = num[Q-1:0];
      q_in[0]   = '0;
      for (int k = 0; k < Q; k++) begin
         trial = {rem_ff[k], nlo_ff[k][Q-1]};
         if (trial >= {1'b0, den_ff[k]}) begin
            rem_in[k+1] = W'(trial - {1'b0, den_ff[k]});
            q_in[k+1]   = {q_ff[k][Q-2:0], 1'b1};
         end else begin
            rem_in[k+1] = trial[W-1:0];
            q_in[k+1]   = {q_ff[k][Q-2:0], 1'b0};
         end
         nlo_in[k+1] = {nlo_ff[k][Q-2:0], 1'b0};
      end
   end

   always_comb begin
      lim = neg_ff[Q] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (ovf_ff[Q] || (q_ff[Q] > lim)) begin
         mag = lim;
      end else begin
         mag = q_ff[Q];
      end
      if (zero_ff[Q]) begin
         quo_in = '0;
      end else if (neg_ff[Q]) begin
         quo_in = $signed(32'd0 - mag);
      end else begin
         quo_in = $signed(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= Q; k++) begin
            rem_ff[k] <= rem_in[k];
            nlo_ff[k] <= nlo_in[k];
            q_ff[k]   <= q_in[k];
         end
         den_ff[0] <= den;
         for (int k = 1; k <= Q; k++) begin
            den_ff[k] <= den_ff[k-1];
         end
         ovf_ff  <= {ovf_ff[Q-1:0], ovf_in};
         neg_ff  <= {neg_ff[Q-1:0], neg};
         zero_ff <= {zero_ff[Q-1:0], zero};
         quo_ff  <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

@@ rtl/radar_measurement_jacobian.sv @@
// radar measurement jacobian: the six distinct nonzero entries of the
// range / bearing / range-rate jacobian of a 2-D constant-velocity state.
// depends on rmj_pkg, rmj_sqrt, rmj_div
//
// A new state can be transferred every clock cycle while the pipeline
// advances; each result passes through the magnitude, product and sum
// stages, the bit-per-stage square root, the wide products and the
// bit-per-stage dividers, in that order. The whole pipeline advances
// together whenever the result register is empty or being taken, so
// req_ready equals that condition and a stall holds every stage in place.
// When the range is below min_range (or zero), too_close is set and the
// six entries are zero. min_range sits at byte address 0 of the csr port
// and should be written only while no item is in flight.
module radar_measurement_jacobian (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rmj_pkg::req_data_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rmj_pkg::rsp_data_type         rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rmj_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rmj_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rmj_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);

   localparam int DW = rmj_pkg::DATA_W;
   localparam int PW = rmj_pkg::PROD_W;
   localparam int F  = rmj_pkg::FRAC_BITS;

   function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
      mag_of = v[DW-1] ? (~v + 32'd1) : v;
   endfunction

   // pipeline advance: result register free or being taken
   logic adv;

   // configuration
   logic [rmj_pkg::MINR_W-1:0] min_range_ff;
   logic                       csr_wr;

   // stage a: magnitudes and signs
   logic          va_ff;
   logic [DW-1:0] a_px_ff, a_py_ff, a_vx_ff, a_vy_ff;
   logic          a_npx_ff, a_npy_ff, a_nvx_ff, a_nvy_ff;

   // stage b: the four products
   logic          vb_ff;
   logic [DW-1:0] b_px_ff, b_py_ff;
   logic [PW-1:0] b_pxx_ff, b_pyy_ff, b_m1_ff, b_m2_ff;
   logic          b_npx_ff, b_npy_ff, b_n1_ff, b_n2_ff;

   // stage c: squared range and cross term in sign-magnitude
   logic              vc_ff;
   rmj_pkg::geom_type c_geom_ff;
   rmj_pkg::geom_type c_geom_in;

   // square root output
   logic              sq_valid;
   logic [rmj_pkg::ROOT_W-1:0] sq_root;
   rmj_pkg::geom_type sq_geom;

   // stage d: range check and partial products
   logic              vd_ff;
   rmj_pkg::geom_type d_geom_ff;
   logic [DW-1:0]     d_root_ff;
   logic              d_tc_ff;
   logic              d_tc_in;
   logic [PW-1:0]     d_sdlo_ff, d_sdhi_ff, d_ylo_ff, d_yhi_ff, d_xlo_ff, d_xhi_ff;

   // stage e: wide numerators and denominators
   logic              ve_ff;
   rmj_pkg::geom_type e_geom_ff;
   logic [DW-1:0]     e_root_ff;
   logic              e_tc_ff;
   rmj_pkg::den_type  e_sd_ff, e_ycm_ff, e_xcm_ff;

   // divider bank
   logic [rmj_pkg::DIV_LAT-1:0] divv_ff;
   logic [rmj_pkg::DIV_LAT-1:0] tc_ff;
   rmj_pkg::num_type  div_num  [rmj_pkg::N_OUT];
   rmj_pkg::den_type  div_den  [rmj_pkg::N_OUT];
   logic [rmj_pkg::N_OUT-1:0] div_neg;
   logic signed [DW-1:0] div_quo [rmj_pkg::N_OUT];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff <= rmj_pkg::MINR_RESET;
      end else if (csr_wr && (csr_paddr[2] == rmj_pkg::CSR_MIN_RANGE)) begin
         min_range_ff <= csr_pwdata[rmj_pkg::MINR_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == rmj_pkg::CSR_MIN_RANGE) begin
         csr_prdata = {1'b0, min_range_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // ---------------------------------------------------------------- valids
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff   <= 1'b0;
         vb_ff   <= 1'b0;
         vc_ff   <= 1'b0;
         vd_ff   <= 1'b0;
         ve_ff   <= 1'b0;
         divv_ff <= '0;
      end else if (adv) begin
         va_ff   <= req_valid;
         vb_ff   <= va_ff;
         vc_ff   <= vb_ff;
         vd_ff   <= sq_valid;
         ve_ff   <= vd_ff;
         divv_ff <= {divv_ff[rmj_pkg::DIV_LAT-2:0], ve_ff};
      end
   end

   // ---------------------------------------------------------------- stages a..c
   always_comb begin
      c_geom_in.px  = b_px_ff;
      c_geom_in.py  = b_py_ff;
      c_geom_in.npx = b_npx_ff;
      c_geom_in.npy = b_npy_ff;
      c_geom_in.s   = b_pxx_ff + b_pyy_ff;
      // cross = vx*py - vy*px
      if (b_n1_ff != b_n2_ff) begin
         c_geom_in.cm = b_m1_ff + b_m2_ff;
         c_geom_in.nc = b_n1_ff;
      end else if (b_m1_ff >= b_m2_ff) begin
         c_geom_in.cm = b_m1_ff - b_m2_ff;
         c_geom_in.nc = b_n1_ff;
      end else begin
         c_geom_in.cm = b_m2_ff - b_m1_ff;
         c_geom_in.nc = !b_n1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_px_ff  <= mag_of(req_data.pos_x);
         a_py_ff  <= mag_of(req_data.pos_y);
         a_vx_ff  <= mag_of(req_data.vel_x);
         a_vy_ff  <= mag_of(req_data.vel_y);
         a_npx_ff <= req_data.pos_x[DW-1];
         a_npy_ff <= req_data.pos_y[DW-1];
         a_nvx_ff <= req_data.vel_x[DW-1];
         a_nvy_ff <= req_data.vel_y[DW-1];

         b_px_ff  <= a_px_ff;
         b_py_ff  <= a_py_ff;
         b_pxx_ff <= a_px_ff * a_px_ff;
         b_pyy_ff <= a_py_ff * a_py_ff;
         b_m1_ff  <= a_vx_ff * a_py_ff;
         b_m2_ff  <= a_vy_ff * a_px_ff;
         b_npx_ff <= a_npx_ff;
         b_npy_ff <= a_npy_ff;
         b_n1_ff  <= a_nvx_ff ^ a_npy_ff;
         b_n2_ff  <= a_nvy_ff ^ a_npx_ff;

         c_geom_ff <= c_geom_in;
      end
   end

   // ---------------------------------------------------------------- range
   rmj_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vc_ff),
      .in_geom   (c_geom_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_geom  (sq_geom)
   );

   // ---------------------------------------------------------------- stages d, e
   // too close when range is zero or under the configured minimum
   assign d_tc_in = (sq_root == '0) || (sq_root < {1'b0, min_range_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         d_geom_ff <= sq_geom;
         d_root_ff <= sq_root;
         d_tc_ff   <= d_tc_in;
         // s*d, py*cm, px*cm split into 32x32 halves
         d_sdlo_ff <= sq_geom.s[DW-1:0]    * sq_root;
         d_sdhi_ff <= sq_geom.s[PW-1:DW]   * sq_root;
         d_ylo_ff  <= sq_geom.cm[DW-1:0]   * sq_geom.py;
         d_yhi_ff  <= sq_geom.cm[PW-1:DW]  * sq_geom.py;
         d_xlo_ff  <= sq_geom.cm[DW-1:0]   * sq_geom.px;
         d_xhi_ff  <= sq_geom.cm[PW-1:DW]  * sq_geom.px;

         e_geom_ff <= d_geom_ff;
         e_root_ff <= d_root_ff;
         e_tc_ff   <= d_tc_ff;
         e_sd_ff   <= rmj_pkg::den_type'(d_sdlo_ff) + (rmj_pkg::den_type'(d_sdhi_ff) << DW);
         e_ycm_ff  <= rmj_pkg::den_type'(d_ylo_ff)  + (rmj_pkg::den_type'(d_yhi_ff)  << DW);
         e_xcm_ff  <= rmj_pkg::den_type'(d_xlo_ff)  + (rmj_pkg::den_type'(d_xhi_ff)  << DW);

         tc_ff <= {tc_ff[rmj_pkg::DIV_LAT-2:0], e_tc_ff};
      end
   end

   // ---------------------------------------------------------------- dividers
   always_comb begin
      // range over px and py
      div_num[0] = rmj_pkg::num_type'(e_geom_ff.px) << F;
      div_den[0] = rmj_pkg::den_type'(e_root_ff);
      div_neg[0] = e_geom_ff.npx;
      div_num[1] = rmj_pkg::num_type'(e_geom_ff.py) << F;
      div_den[1] = rmj_pkg::den_type'(e_root_ff);
      div_neg[1] = e_geom_ff.npy;
      // bearing over px and py
      div_num[2] = rmj_pkg::num_type'(e_geom_ff.py) << (2 * F);
      div_den[2] = rmj_pkg::den_type'(e_geom_ff.s);
      div_neg[2] = !e_geom_ff.npy;
      div_num[3] = rmj_pkg::num_type'(e_geom_ff.px) << (2 * F);
      div_den[3] = rmj_pkg::den_type'(e_geom_ff.s);
      div_neg[3] = e_geom_ff.npx;
      // range rate over px and py
      div_num[4] = rmj_pkg::num_type'(e_ycm_ff) << F;
      div_den[4] = e_sd_ff;
      div_neg[4] = e_geom_ff.npy != e_geom_ff.nc;
      div_num[5] = rmj_pkg::num_type'(e_xcm_ff) << F;
      div_den[5] = e_sd_ff;
      div_neg[5] = e_geom_ff.npx == e_geom_ff.nc;
   end

   for (genvar g = 0; g < rmj_pkg::N_OUT; g++) begin : g_div
      rmj_div u_div (
         .clock (clock),
         .adv   (adv),
         .num   (div_num[g]),
         .den   (div_den[g]),
         .neg   (div_neg[g]),
         .zero  (e_tc_ff),
         .quo   (div_quo[g])
      );
   end

   // ---------------------------------------------------------------- result
   assign rsp_valid             = divv_ff[rmj_pkg::DIV_LAT-1];
   assign rsp_data.drange_dpx   = div_quo[0];
   assign rsp_data.drange_dpy   = div_quo[1];
   assign rsp_data.dbearing_dpx = div_quo[2];
   assign rsp_data.dbearing_dpy = div_quo[3];
   assign rsp_data.drate_dpx    = div_quo[4];
   assign rsp_data.drate_dpy    = div_quo[5];
   assign rsp_data.too_close    = tc_ff[rmj_pkg::DIV_LAT-1];

   // ---------------------------------------------------------------- checks
   // a suppressed result carries only zeros
   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.too_close) |->
         (rsp_data.drange_dpx == '0 && rsp_data.drange_dpy == '0 &&
          rsp_data.dbearing_dpx == '0 && rsp_data.dbearing_dpy == '0 &&
          rsp_data.drate_dpx == '0 && rsp_data.drate_dpy == '0))
      else $error("too_close result with nonzero entries");

   // px never exceeds the floored range, so the range derivative stays within one
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.too_close) |->
         (rsp_data.drange_dpx <= rmj_pkg::UNIT && rsp_data.drange_dpx >= -rmj_pkg::UNIT))
      else $error("range derivative out of unit bound");

   // a csr write to min_range lands on the next edge
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[2] == rmj_pkg::CSR_MIN_RANGE) |=>
         (min_range_ff == $past(csr_pwdata[rmj_pkg::MINR_W-1:0])))
      else $error("min_range write lost");

endmodule
